@@ design/sdt_pkg.sv @@
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared types and constants for the sibling dependency tree decoder.
// ----------------------------------------------------------------------------
package sdt_pkg;

  localparam int POS_W          = 6;
  localparam int LEN_W          = 7;
  localparam int IN_DATA_W      = 56;
  localparam int OUT_DATA_W     = 16;
  localparam int DEF_MAX_TOKENS = 64;
  localparam int DEF_SCORE_BITS = 32;

  // Chart entry kind: direction times three plus span kind.
  typedef enum logic [2:0] {
    CODE_COM_L = 3'd0,
    CODE_INC_L = 3'd1,
    CODE_SIB_L = 3'd2,
    CODE_COM_R = 3'd3,
    CODE_INC_R = 3'd4
  } sdt_code_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_SUM,
    ST_ACC,
    ST_WRITE,
    ST_BT_INIT,
    ST_BT_POP,
    ST_BT_SPLIT,
    ST_BT_EXEC,
    ST_BT_PUSH2,
    ST_EMIT
  } sdt_state_t;

  typedef struct packed {
    logic [POS_W-1:0] s;
    logic [POS_W-1:0] t;
    sdt_code_t        code;
  } sdt_span_t;

  typedef struct packed {
    logic             score_wr;
    logic             rd_issue;
    logic             sum_en;
    logic             acc_en;
    logic             acc_first;
    logic             chart_wr;
    logic             bt_init;
    logic             bt_pop;
    logic             bt_split_rd;
    logic             bt_exec;
    logic             bt_push2;
    logic             emit;
    logic             last;
    sdt_code_t        code;
    logic [POS_W-1:0] s;
    logic [POS_W-1:0] t;
    logic [POS_W-1:0] r;
    logic [POS_W-1:0] word;
  } sdt_cmd_t;

  typedef struct packed {
    logic stack_empty;
    logic out_free;
  } sdt_status_t;

endpackage

@@ design/sibling_dependency_tree_decoder_core.sv @@
// ----------------------------------------------------------------------------
// sibling_dependency_tree_decoder_core
// Second-order sibling projective dependency decoder with score loading.
// ----------------------------------------------------------------------------
// Scores load one per cycle while idle; the tlast transaction starts decoding.
// Each chart entry runs issue, sum and accumulate per split candidate, then one
// write, in the single chart read/accumulate loop. Backtracking pops, reads the
// split, expands and pushes each record, then one result per cycle when out_free.
// Reset is synchronous; sentence length returns to 2 and stack and heads clear.
module sibling_dependency_tree_decoder_core #(
  parameter int MAX_TOKENS = sdt_pkg::DEF_MAX_TOKENS,
  parameter int SCORE_BITS = sdt_pkg::DEF_SCORE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [sdt_pkg::LEN_W-1:0]      cfg_wr_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // head_pos, sibling_pos, modifier_pos, arc_score
  input  logic [sdt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // word_pos, head_of_word
  output logic [sdt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // is_root
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);

  sdt_pkg::sdt_cmd_t    cmd;
  sdt_pkg::sdt_status_t status;

  sdt_controller #(
    .MAX_TOKENS(MAX_TOKENS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tlast (s_axis_tlast),
    .status       (status),
    .cmd          (cmd)
  );

  sdt_datapath #(
    .MAX_TOKENS(MAX_TOKENS),
    .SCORE_BITS(SCORE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

@@ design/sdt_controller.sv @@
// ----------------------------------------------------------------------------
// sdt_controller
// Sequencer for score loading, chart fill, backtracking and head output.
// ----------------------------------------------------------------------------
module sdt_controller #(
  parameter int MAX_TOKENS = sdt_pkg::DEF_MAX_TOKENS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [sdt_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic                     s_axis_tlast,
  input  sdt_pkg::sdt_status_t     status,
  output sdt_pkg::sdt_cmd_t        cmd
);

  localparam int PW = sdt_pkg::POS_W;
  localparam int LW = sdt_pkg::LEN_W;

  sdt_pkg::sdt_state_t state, state_next;
  sdt_pkg::sdt_code_t  code, code_next;
  logic [LW-1:0] n_cfg;
  logic [LW-1:0] n_q, n_q_next;
  logic [PW-1:0] k, k_next;
  logic [PW-1:0] s, s_next;
  logic [PW-1:0] r, r_next;
  logic [PW-1:0] word, word_next;
  logic [PW-1:0] t, lo, hi;
  logic [LW-1:0] n_clamp;

  always_comb begin
    if (n_cfg < LW'(2)) begin
      n_clamp = LW'(2);
    end else if (n_cfg > LW'(MAX_TOKENS)) begin
      n_clamp = LW'(MAX_TOKENS);
    end else begin
      n_clamp = n_cfg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_cfg <= LW'(2);
    end else if (cfg_wr_en) begin
      n_cfg <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdt_pkg::ST_IDLE;
      code  <= sdt_pkg::CODE_SIB_L;
      n_q   <= LW'(2);
      k     <= '0;
      s     <= '0;
      r     <= '0;
      word  <= '0;
    end else begin
      state <= state_next;
      code  <= code_next;
      n_q   <= n_q_next;
      k     <= k_next;
      s     <= s_next;
      r     <= r_next;
      word  <= word_next;
    end
  end

  assign t  = s + k;
  assign lo = (code == sdt_pkg::CODE_COM_R) ? s + PW'(1) : s;
  assign hi = (code == sdt_pkg::CODE_COM_R) ? t : t - PW'(1);

  always_comb begin
    state_next    = state;
    code_next     = code;
    n_q_next      = n_q;
    k_next        = k;
    s_next        = s;
    r_next        = r;
    word_next     = word;
    s_axis_tready = 1'b0;
    cmd           = '0;
    cmd.code      = code;
    cmd.s         = s;
    cmd.t         = t;
    cmd.r         = r;
    cmd.word      = word;
    cmd.last      = ({1'b0, word} == n_q - LW'(1));
    case (state)
      sdt_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.score_wr = 1'b1;
          if (s_axis_tlast) begin
            n_q_next   = n_clamp;
            k_next     = PW'(1);
            s_next     = '0;
            r_next     = '0;
            code_next  = sdt_pkg::CODE_SIB_L;
            state_next = sdt_pkg::ST_ISSUE;
          end
        end
      end
      sdt_pkg::ST_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_next   = sdt_pkg::ST_SUM;
      end
      sdt_pkg::ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = sdt_pkg::ST_ACC;
      end
      sdt_pkg::ST_ACC: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_first = (r == lo);
        if (r == hi) begin
          state_next = sdt_pkg::ST_WRITE;
        end else begin
          r_next     = r + PW'(1);
          state_next = sdt_pkg::ST_ISSUE;
        end
      end
      sdt_pkg::ST_WRITE: begin
        cmd.chart_wr = 1'b1;
        state_next   = sdt_pkg::ST_ISSUE;
        r_next       = s;
        case (code)
          sdt_pkg::CODE_SIB_L: code_next = sdt_pkg::CODE_INC_L;
          sdt_pkg::CODE_INC_L: code_next = sdt_pkg::CODE_INC_R;
          sdt_pkg::CODE_INC_R: code_next = sdt_pkg::CODE_COM_L;
          sdt_pkg::CODE_COM_L: begin
            code_next = sdt_pkg::CODE_COM_R;
            r_next    = s + PW'(1);
          end
          default: begin
            code_next = sdt_pkg::CODE_SIB_L;
            if ({1'b0, s} + LW'(1) + {1'b0, k} < n_q) begin
              s_next = s + PW'(1);
              r_next = s + PW'(1);
            end else if ({1'b0, k} + LW'(1) < n_q) begin
              k_next = k + PW'(1);
              s_next = '0;
              r_next = '0;
            end else begin
              state_next = sdt_pkg::ST_BT_INIT;
            end
          end
        endcase
      end
      sdt_pkg::ST_BT_INIT: begin
        cmd.bt_init = 1'b1;
        cmd.s       = '0;
        cmd.t       = PW'(n_q - LW'(1));
        state_next  = sdt_pkg::ST_BT_POP;
      end
      sdt_pkg::ST_BT_POP: begin
        if (status.stack_empty) begin
          word_next  = '0;
          state_next = sdt_pkg::ST_EMIT;
        end else begin
          cmd.bt_pop = 1'b1;
          state_next = sdt_pkg::ST_BT_SPLIT;
        end
      end
      sdt_pkg::ST_BT_SPLIT: begin
        cmd.bt_split_rd = 1'b1;
        state_next      = sdt_pkg::ST_BT_EXEC;
      end
      sdt_pkg::ST_BT_EXEC: begin
        cmd.bt_exec = 1'b1;
        state_next  = sdt_pkg::ST_BT_PUSH2;
      end
      sdt_pkg::ST_BT_PUSH2: begin
        cmd.bt_push2 = 1'b1;
        state_next   = sdt_pkg::ST_BT_POP;
      end
      sdt_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (cmd.last) begin
            word_next  = '0;
            state_next = sdt_pkg::ST_IDLE;
          end else begin
            word_next = word + PW'(1);
          end
        end
      end
      default: state_next = sdt_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ design/sdt_datapath.sv @@
// ----------------------------------------------------------------------------
// sdt_datapath
// Score store, chart and split memories, maximizer, backtrack stack, heads.
// ----------------------------------------------------------------------------
module sdt_datapath #(
  parameter int MAX_TOKENS = sdt_pkg::DEF_MAX_TOKENS,
  parameter int SCORE_BITS = sdt_pkg::DEF_SCORE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sdt_pkg::sdt_cmd_t             cmd,
  output sdt_pkg::sdt_status_t          status,
  input  logic [sdt_pkg::IN_DATA_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sdt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);

  localparam int PW     = sdt_pkg::POS_W;
  localparam int MT     = MAX_TOKENS;
  localparam int CB     = SCORE_BITS + 8;
  localparam int SA_D   = MT * MT * MT;
  localparam int SA_W   = $clog2(SA_D);
  localparam int CH_D   = 6 * MT * MT;
  localparam int CA_W   = $clog2(CH_D);
  localparam int ST_D   = 2 * MT;
  localparam int ST_W   = $clog2(ST_D);
  localparam int FILL_W = $clog2(ST_D + 1);
  localparam int PI_W   = (MT > 1) ? $clog2(MT) : 1;
  localparam logic signed [CB-1:0] CHART_MIN = {1'b1, {(CB - 1){1'b0}}};
  localparam logic signed [CB-1:0] CHART_MAX = {1'b0, {(CB - 1){1'b1}}};

  function automatic logic signed [CB-1:0] sadd(logic signed [CB-1:0] a,
                                                logic signed [CB-1:0] b);
    logic signed [CB:0] w;
    w = {a[CB-1], a} + {b[CB-1], b};
    if (a == CHART_MIN || b == CHART_MIN) begin
      sadd = CHART_MIN;
    end else if (w[CB] != w[CB-1]) begin
      sadd = w[CB] ? CHART_MIN : CHART_MAX;
    end else begin
      sadd = w[CB-1:0];
    end
  endfunction

  function automatic logic [CA_W-1:0] caddr(sdt_pkg::sdt_span_t sp);
    caddr = CA_W'(int'(sp.code) * MT * MT + int'(sp.s) * MT + int'(sp.t));
  endfunction

  function automatic logic [SA_W-1:0] saddr(logic [PW-1:0] h, logic [PW-1:0] c,
                                            logic [PW-1:0] m);
    saddr = SA_W'(int'(h) * MT * MT + int'(c) * MT + int'(m));
  endfunction

  function automatic sdt_pkg::sdt_span_t mk(logic [PW-1:0] s, logic [PW-1:0] t,
                                            sdt_pkg::sdt_code_t code);
    mk.s    = s;
    mk.t    = t;
    mk.code = code;
  endfunction

  function automatic logic [PW-1:0] split_mem_q_clamp(logic [PW-1:0] v, logic [PW-1:0] lo,
                                                       logic [PW-1:0] hi);
    if (v < lo) begin
      split_mem_q_clamp = lo;
    end else if (v > hi) begin
      split_mem_q_clamp = hi;
    end else begin
      split_mem_q_clamp = v;
    end
  endfunction

  // Score loading.
  logic [PW-1:0]          in_h, in_c, in_m;
  logic [31:0]            in_raw;
  logic signed [SCORE_BITS-1:0] score_in;
  logic                   in_range;
  logic signed [SCORE_BITS-1:0] score_mem [SA_D];

  assign in_h     = s_axis_tdata[5:0];
  assign in_c     = s_axis_tdata[11:6];
  assign in_m     = s_axis_tdata[17:12];
  assign in_raw   = s_axis_tdata[49:18];
  assign in_range = ({1'b0, in_h} < (PW + 1)'(MT)) && ({1'b0, in_c} < (PW + 1)'(MT)) &&
                    ({1'b0, in_m} < (PW + 1)'(MT));

  if (SCORE_BITS >= 32) begin : g_wide
    assign score_in = SCORE_BITS'($signed(in_raw));
  end else begin : g_narrow
    localparam logic signed [31:0] S_MAX = (32'sd1 <<< (SCORE_BITS - 1)) - 32'sd1;
    localparam logic signed [31:0] S_MIN = -(32'sd1 <<< (SCORE_BITS - 1));
    always_comb begin
      if ($signed(in_raw) > S_MAX) begin
        score_in = S_MAX[SCORE_BITS-1:0];
      end else if ($signed(in_raw) < S_MIN) begin
        score_in = S_MIN[SCORE_BITS-1:0];
      end else begin
        score_in = in_raw[SCORE_BITS-1:0];
      end
    end
  end

  // Operand selection for one split candidate.
  sdt_pkg::sdt_span_t opa, opb;
  logic [PW-1:0]      ah, ac, am, sp_c;
  logic               use_arc;

  always_comb begin
    opa     = mk(cmd.s, cmd.r, sdt_pkg::CODE_COM_R);
    opb     = mk(cmd.r + PW'(1), cmd.t, sdt_pkg::CODE_COM_L);
    ah      = cmd.t;
    ac      = cmd.r;
    am      = cmd.s;
    use_arc = 1'b0;
    sp_c    = cmd.r;
    case (cmd.code)
      sdt_pkg::CODE_SIB_L: begin
        opa = mk(cmd.s, cmd.r, sdt_pkg::CODE_COM_R);
        opb = mk(cmd.r + PW'(1), cmd.t, sdt_pkg::CODE_COM_L);
      end
      sdt_pkg::CODE_INC_L: begin
        use_arc = 1'b1;
        if (cmd.r == cmd.s) begin
          opa = mk(cmd.s, cmd.t - PW'(1), sdt_pkg::CODE_COM_R);
          opb = mk(cmd.t, cmd.t, sdt_pkg::CODE_COM_L);
          ac  = cmd.t;
        end else begin
          opa = mk(cmd.s, cmd.r, sdt_pkg::CODE_SIB_L);
          opb = mk(cmd.r, cmd.t, sdt_pkg::CODE_INC_L);
        end
      end
      sdt_pkg::CODE_INC_R: begin
        use_arc = 1'b1;
        ah      = cmd.s;
        am      = cmd.t;
        if (cmd.r == cmd.s) begin
          opa  = mk(cmd.s, cmd.s, sdt_pkg::CODE_COM_R);
          opb  = mk(cmd.s + PW'(1), cmd.t, sdt_pkg::CODE_COM_L);
          sp_c = cmd.t;
        end else begin
          opa = mk(cmd.r, cmd.t, sdt_pkg::CODE_SIB_L);
          opb = mk(cmd.s, cmd.r, sdt_pkg::CODE_INC_R);
        end
      end
      sdt_pkg::CODE_COM_L: begin
        opa = mk(cmd.s, cmd.r, sdt_pkg::CODE_COM_L);
        opb = mk(cmd.r, cmd.t, sdt_pkg::CODE_INC_L);
      end
      default: begin
        opa = mk(cmd.s, cmd.r, sdt_pkg::CODE_INC_R);
        opb = mk(cmd.r, cmd.t, sdt_pkg::CODE_COM_R);
      end
    endcase
  end

  // Chart memories and the running maximum.
  logic signed [CB-1:0] chart_mem [CH_D];
  logic [PW-1:0]        split_mem [CH_D];
  logic signed [CB-1:0] a_q, b_q, sum_q, arcx_q, best, acc_v;
  logic signed [SCORE_BITS-1:0] arc_q;
  logic                 a_diag, b_diag, use_arc_q;
  logic [PW-1:0]        sp_q, sp2_q, best_sp, x_q;

  always_ff @(posedge clk) begin
    if (cmd.score_wr && in_range) begin
      score_mem[saddr(in_h, in_c, in_m)] <= score_in;
    end
    if (cmd.rd_issue) begin
      arc_q <= score_mem[saddr(ah, ac, am)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chart_wr) begin
      chart_mem[caddr(mk(cmd.s, cmd.t, cmd.code))] <= best;
      split_mem[caddr(mk(cmd.s, cmd.t, cmd.code))] <= best_sp;
    end
    if (cmd.rd_issue) begin
      a_q <= chart_mem[caddr(opa)];
      b_q <= chart_mem[caddr(opb)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      a_diag    <= (opa.s == opa.t);
      b_diag    <= (opb.s == opb.t);
      use_arc_q <= use_arc;
      sp_q      <= sp_c;
    end
    if (cmd.sum_en) begin
      sum_q  <= sadd(a_diag ? '0 : a_q, b_diag ? '0 : b_q);
      arcx_q <= use_arc_q ? CB'(arc_q) : '0;
      sp2_q  <= sp_q;
    end
    if (cmd.acc_en && (cmd.acc_first || acc_v >= best)) begin
      best    <= acc_v;
      best_sp <= sp2_q;
    end
  end

  assign acc_v = sadd(sum_q, arcx_q);

  // Backtrack stack and head table.
  sdt_pkg::sdt_span_t stack_mem [ST_D];
  sdt_pkg::sdt_span_t top_q, p1, p2, p2_q, push_rec;
  logic [FILL_W-1:0]  fill, fill_m1;
  logic [PW-1:0]      x, hw_idx, hw_val;
  logic               push_en, push_ok, hw_en;
  logic [PW-1:0]      head_mem [MT];
  logic [MT-1:0]      head_vld;
  logic [PW-1:0]      hd, hd_q, hd_rd_addr;
  logic               hd_vld_q;

  assign fill_m1 = fill - FILL_W'(1);

  always_comb begin
    x = split_mem_q_clamp(x_q, top_q.s, top_q.t);
    p1     = mk('0, '0, sdt_pkg::CODE_COM_L);
    p2     = mk('0, '0, sdt_pkg::CODE_COM_L);
    hw_en  = 1'b0;
    hw_idx = top_q.s;
    hw_val = top_q.t;
    case (top_q.code)
      sdt_pkg::CODE_INC_L: begin
        hw_en = 1'b1;
        if (x == top_q.s) begin
          p1 = mk(top_q.s, top_q.t - PW'(1), sdt_pkg::CODE_COM_R);
        end else begin
          p1 = mk(x, top_q.t, sdt_pkg::CODE_INC_L);
          p2 = mk(top_q.s, x, sdt_pkg::CODE_SIB_L);
        end
      end
      sdt_pkg::CODE_INC_R: begin
        hw_en  = 1'b1;
        hw_idx = top_q.t;
        hw_val = top_q.s;
        if (x == top_q.t) begin
          p1 = mk(top_q.s + PW'(1), top_q.t, sdt_pkg::CODE_COM_L);
        end else begin
          p1 = mk(top_q.s, x, sdt_pkg::CODE_INC_R);
          p2 = mk(x, top_q.t, sdt_pkg::CODE_SIB_L);
        end
      end
      sdt_pkg::CODE_COM_L: begin
        p1 = mk(x, top_q.t, sdt_pkg::CODE_INC_L);
        p2 = mk(top_q.s, x, sdt_pkg::CODE_COM_L);
      end
      sdt_pkg::CODE_COM_R: begin
        p1 = mk(x, top_q.t, sdt_pkg::CODE_COM_R);
        p2 = mk(top_q.s, x, sdt_pkg::CODE_INC_R);
      end
      default: begin
        if (x >= top_q.t) begin
          x = top_q.t - PW'(1);
        end
        p1 = mk(x + PW'(1), top_q.t, sdt_pkg::CODE_COM_L);
        p2 = mk(top_q.s, x, sdt_pkg::CODE_COM_R);
      end
    endcase
  end

  always_comb begin
    push_rec = p1;
    push_en  = 1'b0;
    if (cmd.bt_init) begin
      push_rec = mk(cmd.s, cmd.t, sdt_pkg::CODE_COM_R);
    end else if (cmd.bt_exec) begin
      push_rec = p1;
      push_en  = 1'b1;
    end else if (cmd.bt_push2) begin
      push_rec = p2_q;
      push_en  = 1'b1;
    end
  end

  assign push_ok = push_en && (push_rec.s < push_rec.t) && (fill < FILL_W'(ST_D));

  always_ff @(posedge clk) begin
    if (cmd.bt_init) begin
      stack_mem[0] <= push_rec;
    end else if (push_ok) begin
      stack_mem[fill[ST_W-1:0]] <= push_rec;
    end
    if (cmd.bt_pop) begin
      top_q <= stack_mem[fill_m1[ST_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bt_split_rd) begin
      x_q <= split_mem[caddr(top_q)];
    end
    if (cmd.bt_exec) begin
      p2_q <= p2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.bt_init) begin
      fill <= FILL_W'(1);
    end else if (cmd.bt_pop) begin
      fill <= fill_m1;
    end else if (push_ok) begin
      fill <= fill + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= '0;
    end else if (cmd.bt_init) begin
      head_vld <= '0;
    end else if (cmd.bt_exec && hw_en) begin
      head_vld[hw_idx[PI_W-1:0]] <= 1'b1;
    end
  end

  // The head table is read one word ahead so that each result has its entry ready.
  assign hd_rd_addr = (cmd.emit && !cmd.last) ? cmd.word + PW'(1) : cmd.word;

  always_ff @(posedge clk) begin
    if (cmd.bt_exec && hw_en) begin
      head_mem[hw_idx[PI_W-1:0]] <= hw_val;
    end
    hd_q     <= head_mem[hd_rd_addr[PI_W-1:0]];
    hd_vld_q <= head_vld[hd_rd_addr[PI_W-1:0]];
  end

  // Result register.
  assign hd = (cmd.word == '0 || !hd_vld_q) ? '0 : hd_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_axis_tdata <= {4'b0, hd, cmd.word};
      m_axis_tuser <= (cmd.word == '0);
      m_axis_tlast <= cmd.last;
    end
  end

  assign status.stack_empty = (fill == '0);
  assign status.out_free    = !m_axis_tvalid || m_axis_tready;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.bt_pop |-> fill != '0)
    else $error("stack popped while empty");

  a_chart_offdiag: assert property (@(posedge clk) disable iff (rst)
    cmd.chart_wr |-> cmd.s < cmd.t)
    else $error("chart write on a diagonal span");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before it was taken");

  a_acc_after_sum: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_en |-> $past(cmd.sum_en))
    else $error("accumulate without a preceding sum");

endmodule

@@ tb/sibling_dependency_tree_decoder_core_checker.sv @@
// ----------------------------------------------------------------------------
// Dependency decoder checker
// Watches the configuration port and both stream channels. It mirrors the
// score store, fills its own second-order sibling chart when a sentence ends,
// walks the split table for the head of each token, and compares every result
// transaction in order against the parse it predicts.
// ----------------------------------------------------------------------------
module sibling_dependency_tree_decoder_core_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [sdt_pkg::LEN_W-1:0]      cfg_wr_data,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [sdt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tlast,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [sdt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           m_axis_tuser,
  input  logic                           m_axis_tlast,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTOK = 64;
  localparam longint CHART_LO = -(longint'(1) << 39);
  localparam longint CHART_HI = (longint'(1) << 39) - 1;

  typedef struct {
    logic [5:0] word;
    logic [5:0] head;
    logic       root;
    logic       last;
  } head_result_t;

  logic signed [31:0]         arc_store [0:NTOK*NTOK*NTOK-1];
  longint                     chart_val [0:NTOK*NTOK*6-1];
  logic [5:0]                 chart_split [0:NTOK*NTOK*6-1];
  int                         head_of [0:NTOK-1];
  sdt_pkg::sdt_span_t         span_stack [0:2*NTOK-1];
  int                         stack_fill;
  logic [sdt_pkg::LEN_W-1:0]  sent_len;
  head_result_t               parse_q [$];

  function automatic int cx(int s, int t, sdt_pkg::sdt_code_t c);
    return (s * NTOK + t) * 6 + int'(c);
  endfunction

  function automatic longint arc_at(int h, int c, int m);
    return longint'(arc_store[(h * NTOK + c) * NTOK + m]);
  endfunction

  function automatic longint sat_add(longint a, longint b);
    longint r;
    if (a == CHART_LO || b == CHART_LO) return CHART_LO;
    r = a + b;
    if (r < CHART_LO) r = CHART_LO;
    if (r > CHART_HI) r = CHART_HI;
    return r;
  endfunction

  function automatic void put_entry(int i, longint v, int sp);
    chart_val[i] = v;
    chart_split[i] = sp[5:0];
  endfunction

  function automatic void fill_chart(int n);
    int t;
    int sp;
    longint best;
    longint v;
    for (int s = 0; s < n; s++)
      for (int i = 0; i < 5; i++) put_entry(cx(s, s, sdt_pkg::sdt_code_t'(i)), 0, s);
    for (int k = 1; k < n; k++) begin
      for (int s = 0; s + k < n; s++) begin
        t = s + k;
        best = CHART_LO; sp = s;
        for (int r = s; r < t; r++) begin
          v = sat_add(chart_val[cx(s, r, sdt_pkg::CODE_COM_R)],
                      chart_val[cx(r + 1, t, sdt_pkg::CODE_COM_L)]);
          if (v >= best) begin best = v; sp = r; end
        end
        put_entry(cx(s, t, sdt_pkg::CODE_SIB_L), best, sp);

        best = sat_add(sat_add(chart_val[cx(s, t - 1, sdt_pkg::CODE_COM_R)],
                               chart_val[cx(t, t, sdt_pkg::CODE_COM_L)]), arc_at(t, t, s));
        sp = s;
        for (int r = s + 1; r < t; r++) begin
          v = sat_add(sat_add(chart_val[cx(s, r, sdt_pkg::CODE_SIB_L)],
                              chart_val[cx(r, t, sdt_pkg::CODE_INC_L)]),
                      arc_at(t, r, s));
          if (v >= best) begin best = v; sp = r; end
        end
        put_entry(cx(s, t, sdt_pkg::CODE_INC_L), best, sp);

        best = sat_add(sat_add(chart_val[cx(s, s, sdt_pkg::CODE_COM_R)],
                               chart_val[cx(s + 1, t, sdt_pkg::CODE_COM_L)]), arc_at(s, s, t));
        sp = t;
        for (int r = s + 1; r < t; r++) begin
          v = sat_add(sat_add(chart_val[cx(r, t, sdt_pkg::CODE_SIB_L)],
                              chart_val[cx(s, r, sdt_pkg::CODE_INC_R)]),
                      arc_at(s, r, t));
          if (v >= best) begin best = v; sp = r; end
        end
        put_entry(cx(s, t, sdt_pkg::CODE_INC_R), best, sp);

        best = CHART_LO; sp = s;
        for (int r = s; r < t; r++) begin
          v = sat_add(chart_val[cx(s, r, sdt_pkg::CODE_COM_L)],
                      chart_val[cx(r, t, sdt_pkg::CODE_INC_L)]);
          if (v >= best) begin best = v; sp = r; end
        end
        put_entry(cx(s, t, sdt_pkg::CODE_COM_L), best, sp);

        best = CHART_LO; sp = t;
        for (int r = s + 1; r <= t; r++) begin
          v = sat_add(chart_val[cx(s, r, sdt_pkg::CODE_INC_R)],
                      chart_val[cx(r, t, sdt_pkg::CODE_COM_R)]);
          if (v >= best) begin best = v; sp = r; end
        end
        put_entry(cx(s, t, sdt_pkg::CODE_COM_R), best, sp);
      end
    end
  endfunction

  function automatic void push_span(int s, int t, sdt_pkg::sdt_code_t c);
    if (stack_fill >= 2 * NTOK || s >= t) return;
    span_stack[stack_fill] = '{s: s[5:0], t: t[5:0], code: c};
    stack_fill++;
  endfunction

  function automatic void trace_heads(int n);
    sdt_pkg::sdt_span_t e;
    int s;
    int t;
    int x;
    stack_fill = 0;
    push_span(0, n - 1, sdt_pkg::CODE_COM_R);
    while (stack_fill > 0) begin
      stack_fill--;
      e = span_stack[stack_fill];
      s = int'(e.s);
      t = int'(e.t);
      x = int'(chart_split[cx(s, t, e.code)]);
      if (x < s) x = s;
      if (x > t) x = t;
      case (e.code)
        sdt_pkg::CODE_INC_L: begin
          head_of[s] = t;
          if (x == s) push_span(s, t - 1, sdt_pkg::CODE_COM_R);
          else begin
            push_span(x, t, sdt_pkg::CODE_INC_L);
            push_span(s, x, sdt_pkg::CODE_SIB_L);
          end
        end
        sdt_pkg::CODE_INC_R: begin
          head_of[t] = s;
          if (x == t) push_span(s + 1, t, sdt_pkg::CODE_COM_L);
          else begin
            push_span(s, x, sdt_pkg::CODE_INC_R);
            push_span(x, t, sdt_pkg::CODE_SIB_L);
          end
        end
        sdt_pkg::CODE_COM_L: begin
          push_span(x, t, sdt_pkg::CODE_INC_L);
          push_span(s, x, sdt_pkg::CODE_COM_L);
        end
        sdt_pkg::CODE_COM_R: begin
          push_span(x, t, sdt_pkg::CODE_COM_R);
          push_span(s, x, sdt_pkg::CODE_INC_R);
        end
        default: begin
          if (x >= t) x = t - 1;
          push_span(x + 1, t, sdt_pkg::CODE_COM_L);
          push_span(s, x, sdt_pkg::CODE_COM_R);
        end
      endcase
    end
  endfunction

  function automatic int decode_sentence();
    int n;
    head_result_t res;
    n = int'(sent_len);
    if (n < 2) n = 2;
    if (n > NTOK) n = NTOK;
    for (int i = 0; i < NTOK; i++) head_of[i] = -1;
    fill_chart(n);
    trace_heads(n);
    for (int i = 0; i < n; i++) begin
      res.word = i[5:0];
      res.head = (i == 0 || head_of[i] < 0) ? 6'd0 : head_of[i][5:0];
      res.root = (i == 0);
      res.last = (i == n - 1);
      parse_q.push_back(res);
    end
    return n;
  endfunction

  task automatic report(string what, int exp_v, int got_v);
    $display("%0t: mismatch in %s: expected %0d, got %0d", $time, what, exp_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    int delta;
    head_result_t exp_r;
    delta = 0;
    if (rst) begin
      fail_count = 0;
      sent_len <= 7'd2;
      pending <= 0;
      parse_q.delete();
    end else begin
      if (cfg_wr_en) sent_len <= cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        arc_store[(int'(s_axis_tdata[5:0]) * NTOK + int'(s_axis_tdata[11:6])) * NTOK
                  + int'(s_axis_tdata[17:12])] = s_axis_tdata[49:18];
        if (s_axis_tlast) delta += decode_sentence();
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (parse_q.size() == 0) begin
          report("unexpected result transaction, word", -1, int'(m_axis_tdata[5:0]));
        end else begin
          exp_r = parse_q.pop_front();
          delta -= 1;
          if (m_axis_tdata[5:0] != exp_r.word)
            report("word_pos", int'(exp_r.word), int'(m_axis_tdata[5:0]));
          if (m_axis_tdata[11:6] != exp_r.head)
            report("head_of_word", int'(exp_r.head), int'(m_axis_tdata[11:6]));
          if (m_axis_tuser != exp_r.root)
            report("is_root", int'(exp_r.root), int'(m_axis_tuser));
          if (m_axis_tlast != exp_r.last)
            report("last_word", int'(exp_r.last), int'(m_axis_tlast));
        end
      end
      pending <= pending + delta;
    end
  end

endmodule

@@ tb/sibling_dependency_tree_decoder_core_test.sv @@
// ----------------------------------------------------------------------------
// Dependency decoder testbench
// Loads sibling arc scores for sentences of varying length, closes each one
// with a final transaction, and lets the checker verify the reported heads.
// Runs with both sides stalling at random, a long output hold-off and
// configuration changes between sentences.
// ----------------------------------------------------------------------------
module sibling_dependency_tree_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int MAX_DECODE = 8;
  localparam int LW = sdt_pkg::LEN_W;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_wr_en = 1'b0;
  logic [LW-1:0]                  cfg_wr_data = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [sdt_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           s_axis_tlast = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [sdt_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           m_axis_tlast;
  int                             fail_count;
  int                             pending;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_output = 1'b0;
  int  cycles = 0;
  int  items_sent = 0;
  int  sentences = 0;
  bit  arc_loaded [0:64*64*64-1];

  sibling_dependency_tree_decoder_core dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
  );

  sibling_dependency_tree_decoder_core_checker u_checker (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk)
    m_axis_tready <= hold_output ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);

  function automatic logic [31:0] pick_score();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'($urandom_range(4)) << 16;
      4: return -(32'($urandom_range(4)) << 16);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_arc(int h, int c, int m, logic [31:0] score, bit fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, score, m[5:0], c[5:0], h[5:0]};
    s_axis_tlast <= fin;
    arc_loaded[(h * 64 + c) * 64 + m] = 1'b1;
    items_sent++;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_needed(int h, int c, int m);
    if (!arc_loaded[(h * 64 + c) * 64 + m]) send_arc(h, c, m, pick_score(), 1'b0);
  endtask

  // Loads every arc the chart of an n-token sentence reads that is still
  // unwritten, then some random arcs, then the final transaction.
  task automatic run_sentence(int n, int extra);
    for (int t = 1; t < n; t++)
      for (int s = 0; s < t; s++) begin
        send_needed(t, t, s);
        send_needed(s, s, t);
        for (int r = s + 1; r < t; r++) begin
          send_needed(t, r, s);
          send_needed(s, r, t);
        end
      end
    repeat (extra) begin
      if ($urandom_range(1)) begin
        send_arc($urandom_range(63), $urandom_range(63), $urandom_range(63), pick_score(), 1'b0);
      end else begin
        int t;
        int s;
        t = $urandom_range(n - 1, 1);
        s = $urandom_range(t - 1);
        if ($urandom_range(1)) send_arc(t, $urandom_range(t, s + 1), s, pick_score(), 1'b0);
        else send_arc(s, $urandom_range(t - 1, s), t, pick_score(), 1'b0);
      end
    end
    send_arc($urandom_range(n - 1), $urandom_range(n - 1), $urandom_range(n - 1),
             pick_score(), 1'b1);
    sentences++;
  endtask

  task automatic drain_and_config(logic [LW-1:0] len);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (50) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_phase(int target, int send_pct, int recv_pct, bit with_hold);
    int n;
    int stop_at;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    n = $urandom_range(MAX_DECODE, 2);
    drain_and_config(LW'(n));
    if (with_hold) begin
      fork
        begin
          hold_output = 1'b1;
          repeat (3000) @(posedge clk);
          hold_output = 1'b0;
        end
      join_none
    end
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      if ($urandom_range(3) == 0) begin
        n = $urandom_range(MAX_DECODE, 2);
        drain_and_config(LW'(n));
      end
      run_sentence(n, $urandom_range(6));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: lengths below the minimum saturate to two tokens.
    drain_and_config(7'd1);
    send_arc(1, 1, 0, 32'h7fff_ffff, 1'b0);
    send_arc(0, 0, 1, 32'h8000_0000, 1'b1);
    drain_and_config(7'd0);
    send_arc(1, 1, 0, 32'h8000_0000, 1'b0);
    send_arc(0, 0, 1, 32'h7fff_ffff, 1'b1);
    // All-zero scores on three tokens make every split a tie.
    drain_and_config(7'd3);
    send_arc(63, 63, 63, 32'hffff_ffff, 1'b0);
    for (int t = 1; t < 3; t++)
      for (int s = 0; s < t; s++)
        for (int r = s; r <= t; r++) begin
          if (r != s) send_arc(t, r, s, 32'h0, 1'b0);
          if (r != t) send_arc(s, r, t, 32'h0, 1'b0);
        end
    send_arc(0, 0, 0, 32'h0, 1'b1);
    // Largest lengths are written once but not decoded here.
    drain_and_config(7'd64);
    drain_and_config(7'd127);
    drain_and_config(7'd3);
    send_arc(2, 1, 0, 32'h7fff_ffff, 1'b0);
    send_arc(0, 1, 2, 32'h7fff_ffff, 1'b1);

    random_phase(160, 28, 67, 1'b0);
    random_phase(160, 67, 28, 1'b0);
    random_phase(160, 0, 0, 1'b1);

    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2000) @(posedge clk);

    $display("Sent %0d score transactions in %0d sentences of 2 to %0d tokens.",
             items_sent, sentences, MAX_DECODE);
    $display("Covered saturated scores, tie-heavy charts, length saturation and stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
